@@ sv/ptsd_pkg.sv @@
// Package for the PWM temperature sensor decoder.
// Holds widths, register indexes, reset values and the control interface types.
// No dependencies.
package ptsd_pkg;

   localparam int COUNTER_WIDTH_DEF = 32;
   localparam int FRACTION_BITS_DEF = 4;

   localparam int TIME_W   = 32;
   localparam int TEMP_W   = 16;
   localparam int OFFSET_W = 10;
   localparam int SLOPE_W  = 11;

   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_TEMP_OFFSET = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_TEMP_SLOPE  = CSR_IDX_W'(1);

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(421);
   localparam logic [SLOPE_W-1:0]  SLOPE_RESET  = SLOPE_W'(751);

   localparam int TEMP_MAX = 32767;
   localparam int TEMP_MIN = -32768;

   typedef struct packed {
      logic capture;
      logic mul;
      logic div_step;
      logic diff;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

@@ sv/ptsd_ctrl.sv @@
// Controller state machine for the PWM temperature sensor decoder.
// Sequences capture, multiply, divide, difference and output load.
// Depends on ptsd_pkg.
module ptsd_ctrl
   import ptsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_DIFF = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.capture  = req_tvalid && req_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ sv/ptsd_dp.sv @@
// Datapath for the PWM temperature sensor decoder.
// Holds the capture state, the slope multiplier, a restoring divider and the result register.
// Depends on ptsd_pkg.
module ptsd_dp
   import ptsd_pkg::*;
#(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic [TIME_W-1:0]     capture_time,
   input  logic                  rising_edge,
   output logic [TIME_W-1:0]     high_time,
   output logic [TIME_W-1:0]     low_time,
   output logic [TEMP_W-1:0]     temperature,
   output logic                  saturated
);

   localparam int CW    = COUNTER_WIDTH;
   localparam int NW    = SLOPE_W + CW + FRACTION_BITS;
   localparam int DW    = NW + 2;
   localparam int CNT_W = $clog2(NW);

   localparam logic signed [DW-1:0] SAT_HI = DW'(TEMP_MAX);
   localparam logic signed [DW-1:0] SAT_LO = DW'(TEMP_MIN);

   logic [OFFSET_W-1:0] offset_ff;
   logic [SLOPE_W-1:0]  slope_ff;
   logic [CW-1:0]       last_ff, high_ff, low_ff;
   logic [CW-1:0]       now, dt;
   logic [SLOPE_W+CW-1:0] prod;
   logic [NW-1:0]       quo_ff;
   logic [CW-1:0]       rem_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic signed [DW-1:0] res_ff;
   logic [CW:0]         rem_sh;
   logic                ge;
   logic [DW-1:0]       a_val;
   logic signed [DW-1:0] diff, diff_m1, res_in;
   logic [TIME_W-1:0]   high_out_ff, low_out_ff;
   logic [TEMP_W-1:0]   temp_ff, temp_in;
   logic                sat_ff, sat_in;

   assign now = capture_time[CW-1:0];
   assign dt  = now - last_ff;

   assign prod = slope_ff * high_ff;

   assign rem_sh = {rem_ff, quo_ff[NW-1]};
   assign ge     = rem_sh >= (CW+1)'(low_ff);
   assign status.div_last = (cnt_ff == CNT_W'(NW - 1));

   assign a_val   = DW'(offset_ff) << FRACTION_BITS;
   assign diff    = $signed(a_val - DW'(quo_ff));
   assign diff_m1 = $signed(a_val + ~DW'(quo_ff));
   assign res_in  = ((rem_ff != '0) && (diff > 0)) ? diff_m1 : diff;

   always_comb begin
      temp_in = res_ff[TEMP_W-1:0];
      sat_in  = 1'b0;
      if (low_ff == '0) begin
         temp_in = '0;
      end else if (res_ff > SAT_HI) begin
         temp_in = SAT_HI[TEMP_W-1:0];
         sat_in  = 1'b1;
      end else if (res_ff < SAT_LO) begin
         temp_in = SAT_LO[TEMP_W-1:0];
         sat_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
         slope_ff  <= SLOPE_RESET;
         last_ff   <= '0;
         high_ff   <= CW'(1);
         low_ff    <= CW'(1);
      end else begin
         if (csr_write && (csr_index == REG_TEMP_OFFSET)) begin
            offset_ff <= csr_data[OFFSET_W-1:0];
         end
         if (csr_write && (csr_index == REG_TEMP_SLOPE)) begin
            slope_ff <= csr_data[SLOPE_W-1:0];
         end
         if (cmd.capture) begin
            last_ff <= now;
            if (rising_edge) begin
               low_ff <= dt;
            end else begin
               high_ff <= dt;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         quo_ff <= NW'(prod) << FRACTION_BITS;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[NW-2:0], ge};
         rem_ff <= ge ? CW'(rem_sh - (CW+1)'(low_ff)) : rem_sh[CW-1:0];
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (cmd.diff) begin
         res_ff <= res_in;
      end
      if (cmd.load_out) begin
         high_out_ff <= TIME_W'(high_ff);
         low_out_ff  <= TIME_W'(low_ff);
         temp_ff     <= temp_in;
         sat_ff      <= sat_in;
      end
   end

   assign high_time   = high_out_ff;
   assign low_time    = low_out_ff;
   assign temperature = temp_ff;
   assign saturated   = sat_ff;

endmodule

@@ sv/pwm_temperature_sensor_decoder.sv @@
// Top level of the PWM temperature sensor decoder.
// Joins the controller and the datapath to the stream and register ports.
// Depends on ptsd_pkg, ptsd_ctrl and ptsd_dp.
//
// Each req beat is one timer capture: tdata holds the timestamp, tuser is set
// for a rising edge. The block updates the high or low duration and returns one
// rsp beat with both durations and the temperature in 1/2^FRACTION_BITS degree.
// rsp_tuser is set when the temperature was clipped to 16 bits.
// Each item passes from accept through the multiply, divide, difference and output
// states to a valid result, with the restoring divider producing one quotient bit
// per cycle. One item is worked on at a time and the next beat is taken in the
// cycle after the result is loaded into the output register.
// The result sits in an output register, so the next beat is accepted while a
// result waits; when rsp_tready stays low the finished result of the next item
// holds in the datapath until the output register frees.
// Registers are to be written through the csr port only while the block is
// idle, which the block does not enforce; index 0 is the offset, index 1 the
// slope, csr_ready is always high. Reset is synchronous and restores the
// register defaults, the last capture to zero and both durations to one.
module pwm_temperature_sensor_decoder
   import ptsd_pkg::*;
#(
   parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF,
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [31:0]           req_tdata,  // capture_time
   input  logic                  req_tuser,  // rising_edge
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [79:0]           rsp_tdata,  // high_time, low_time, temperature
   output logic                  rsp_tuser,  // saturated
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type           cmd;
   status_type        status;
   logic [TIME_W-1:0] high_time, low_time;
   logic [TEMP_W-1:0] temperature;

   assign csr_ready = 1'b1;

   ptsd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ptsd_dp #(
      .COUNTER_WIDTH (COUNTER_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_write    (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .capture_time (req_tdata),
      .rising_edge  (req_tuser),
      .high_time    (high_time),
      .low_time     (low_time),
      .temperature  (temperature),
      .saturated    (rsp_tuser)
   );

   assign rsp_tdata = {temperature, low_time, high_time};

endmodule

@@ verif/pwm_temperature_sensor_decoder_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for pwm_temperature_sensor_decoder: timer captures go in on the req
// stream, and every rsp beat is checked against a predictor or a directed expected reading.
// Depends on ptsd_pkg and pwm_temperature_sensor_decoder.
module pwm_temperature_sensor_decoder_tb
   import ptsd_pkg::*;
;

   localparam int BLOCK_LATENCY = 4 + SLOPE_W + COUNTER_WIDTH_DEF + FRACTION_BITS_DEF;
   localparam int HOLD_CYCLES = 600;
   localparam int PHASES = 6;
   localparam int PHASE_ITEMS = 140;
   localparam int GAP_SLOW = 14;
   localparam logic [PHASES-1:0] SND_SLOW = 6'b101010;
   localparam logic [PHASES-1:0] RCV_SLOW = 6'b010011;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = '1;

   typedef struct packed {
      logic [TIME_W-1:0]        high_time;
      logic [TIME_W-1:0]        low_time;
      logic signed [TEMP_W-1:0] temperature;
      logic                     saturated;
   } sensor_reading_type;

   typedef enum logic {ROW_CAPTURE, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] index;
      logic [TIME_W-1:0]    stamp;
      logic                 rising;
      logic                 known;
      sensor_reading_type   typed;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [31:0]           req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [79:0]           rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   sensor_reading_type  pending_readings[$];
   int                  errors = 0;
   int                  snd_gap_max = 14;
   int                  rcv_gap_max = 14;
   bit                  hold_pending = 1'b0;
   logic [OFFSET_W-1:0] cfg_offset = OFFSET_RESET;
   logic [SLOPE_W-1:0]  cfg_slope = SLOPE_RESET;
   logic [TIME_W-1:0]   prev_stamp = '0;
   logic [TIME_W-1:0]   high_ticks = 1;
   logic [TIME_W-1:0]   low_ticks = 1;

   pwm_temperature_sensor_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic sensor_reading_type predict_reading(input logic [TIME_W-1:0] stamp,
                                                          input logic rising);
      logic [TIME_W-1:0]  interval;
      longint             span_hi;
      longint             span_lo;
      longint             quotient;
      sensor_reading_type r;
      interval = stamp - prev_stamp;
      prev_stamp = stamp;
      if (rising) begin
         low_ticks = interval;
      end else begin
         high_ticks = interval;
      end
      span_hi = longint'(high_ticks);
      span_lo = longint'(low_ticks);
      r.high_time = high_ticks;
      r.low_time = low_ticks;
      r.temperature = '0;
      r.saturated = 1'b0;
      if (span_lo != 0) begin
         quotient = ((longint'(cfg_offset) * span_lo - longint'(cfg_slope) * span_hi)
                     * (longint'(1) << FRACTION_BITS_DEF)) / span_lo;
         if (quotient > TEMP_MAX) begin
            quotient = TEMP_MAX;
            r.saturated = 1'b1;
         end else if (quotient < TEMP_MIN) begin
            quotient = TEMP_MIN;
            r.saturated = 1'b1;
         end
         r.temperature = TEMP_W'(quotient);
      end
      return r;
   endfunction

   function automatic plan_row_type capture_row(input logic [TIME_W-1:0] stamp,
                                                input logic rising);
      plan_row_type row;
      row = '0;
      row.kind = ROW_CAPTURE;
      row.stamp = stamp;
      row.rising = rising;
      return row;
   endfunction

   function automatic plan_row_type known_row(input logic [TIME_W-1:0] stamp, input logic rising,
                                              input logic [TIME_W-1:0] hi,
                                              input logic [TIME_W-1:0] lo,
                                              input logic signed [TEMP_W-1:0] temp,
                                              input logic sat);
      plan_row_type row;
      row = capture_row(stamp, rising);
      row.known = 1'b1;
      row.typed = '{hi, lo, temp, sat};
      return row;
   endfunction

   function automatic plan_row_type csr_row(input logic [CSR_IDX_W-1:0] index,
                                            input logic [CSR_DATA_W-1:0] data);
      plan_row_type row;
      row = '0;
      row.kind = ROW_CSR;
      row.index = index;
      row.stamp = TIME_W'(data);
      return row;
   endfunction

   // Called at a falling edge; returns at the falling edge after the beat was taken.
   task automatic send_capture(input logic [TIME_W-1:0] stamp, input logic rising,
                               input logic known, input sensor_reading_type typed);
      int                 gap;
      sensor_reading_type predicted;
      gap = $urandom_range(0, snd_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= stamp;
      req_tuser <= rising;
      do @(posedge clock); while (!req_tready);
      predicted = predict_reading(stamp, rising);
      pending_readings.push_back(known ? typed : predicted);
      @(negedge clock);
   endtask

   task automatic end_burst();
      req_tvalid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      while (pending_readings.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         REG_TEMP_OFFSET: cfg_offset = data[OFFSET_W-1:0];
         REG_TEMP_SLOPE:  cfg_slope = data[SLOPE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin : capture_source
      plan_row_type      directed_plan[$];
      logic [TIME_W-1:0] interval;
      logic [TIME_W-1:0] stamp;
      logic              rising;
      int                draw;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      rising = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The first event after reset measures from zero and sees a zero low time; the
      // third wraps the counter, and a repeated edge overwrites its own duration.
      directed_plan = '{
         known_row(32'h0000_0000, 1'b1, 32'h1, 32'h0, 16'sd0, 1'b0),
         known_row(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'h0, 16'sd0, 1'b0),
         known_row(32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 32'h1, TEMP_W'(TEMP_MIN), 1'b1),
         capture_row(32'h0000_0001, 1'b0),
         known_row(32'h0000_0001, 1'b0, 32'h0, 32'h1, 16'sd6736, 1'b0),
         capture_row(32'h0000_0065, 1'b1),
         capture_row(32'h0000_0097, 1'b0),
         capture_row(32'h8000_0000, 1'b1),
         capture_row(32'hAAAA_AAAA, 1'b0),
         capture_row(32'h5555_5555, 1'b1),
         csr_row(REG_TEMP_OFFSET, 16'hFFFF),
         csr_row(REG_TEMP_SLOPE, 16'h0000),
         capture_row(32'h5555_5655, 1'b0),
         known_row(32'h5555_5755, 1'b1, 32'h100, 32'h100, 16'sd16368, 1'b0),
         csr_row(REG_TEMP_OFFSET, 16'h0000),
         csr_row(REG_TEMP_SLOPE, 16'hFFFF),
         known_row(32'h5555_5756, 1'b1, 32'h100, 32'h1, TEMP_W'(TEMP_MIN), 1'b1),
         known_row(32'h5555_5756, 1'b1, 32'h100, 32'h0, 16'sd0, 1'b0),
         csr_row(REG_SPARE, 16'hFFFF),
         known_row(32'h5555_5757, 1'b0, 32'h1, 32'h0, 16'sd0, 1'b0),
         capture_row(32'h5555_5800, 1'b1),
         capture_row(32'hFFFF_FFF0, 1'b0),
         capture_row(32'h0000_0123, 1'b1)
      };
      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_CSR) begin
            end_burst();
            wait_idle();
            write_csr(directed_plan[i].index, directed_plan[i].stamp[CSR_DATA_W-1:0]);
         end else begin
            send_capture(directed_plan[i].stamp, directed_plan[i].rising,
                         directed_plan[i].known, directed_plan[i].typed);
         end
      end
      rising = 1'b1;

      for (int p = 0; p < PHASES; p++) begin
         end_burst();
         wait_idle();
         case (p)
            0: begin
               write_csr(REG_TEMP_OFFSET, CSR_DATA_W'(OFFSET_RESET));
               write_csr(REG_TEMP_SLOPE, CSR_DATA_W'(SLOPE_RESET));
            end
            1: begin
               write_csr(REG_TEMP_OFFSET, 16'hFFFF);
               write_csr(REG_TEMP_SLOPE, 16'hFFFF);
            end
            2: begin
               write_csr(REG_TEMP_OFFSET, 16'h0000);
               write_csr(REG_TEMP_SLOPE, 16'h0000);
            end
            4: begin
               write_csr(REG_TEMP_OFFSET, 16'hFFFF);
               write_csr(REG_TEMP_SLOPE, 16'h0000);
            end
            default: begin
               write_csr(CSR_IDX_W'($urandom_range(2, 255)), CSR_DATA_W'($urandom));
               write_csr(REG_TEMP_OFFSET, CSR_DATA_W'($urandom));
               write_csr(REG_TEMP_SLOPE, CSR_DATA_W'($urandom));
            end
         endcase
         snd_gap_max = SND_SLOW[p] ? GAP_SLOW : 0;
         rcv_gap_max = RCV_SLOW[p] ? GAP_SLOW : 0;
         if (p == 0) begin
            hold_pending = 1'b1;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            draw = $urandom_range(0, 99);
            if (draw < 75) begin
               // Alternating edges; the high phase is sized against the last low phase
               // so that the ratio sweeps the unsaturated temperature range.
               rising = !rising;
               if (rising) begin
                  case ($urandom_range(0, 9))
                     0, 1: interval = $urandom_range(0, 15);
                     2: interval = $urandom;
                     default: interval = $urandom_range(16, 200000);
                  endcase
               end else begin
                  interval = TIME_W'((64'(low_ticks) * $urandom_range(0, 48)) >> 5);
               end
               stamp = prev_stamp + interval;
            end else if (draw < 90) begin
               stamp = prev_stamp + $urandom_range(0, 4095);
            end else begin
               stamp = $urandom;
               rising = 1'($urandom_range(0, 1));
            end
            send_capture(stamp, rising, 1'b0, '0);
         end
      end

      end_burst();
      wait_idle();
      repeat (2 * BLOCK_LATENCY) @(negedge clock);
      if (errors == 0 && pending_readings.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : reading_sink
      int                 wait_cycles;
      sensor_reading_type got;
      sensor_reading_type want;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         wait_cycles = $urandom_range(0, rcv_gap_max);
         if (hold_pending) begin
            hold_pending = 1'b0;
            wait_cycles += HOLD_CYCLES;
         end
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[79:64], rsp_tuser};
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected beat high %h low %h temp %0d sat %b", $time,
                     got.high_time, got.low_time, got.temperature, got.saturated);
            errors++;
         end else begin
            want = pending_readings.pop_front();
            if (got !== want) begin
               $display("%0t: expected high %h low %h temp %0d sat %b, got high %h low %h temp %0d sat %b",
                        $time, want.high_time, want.low_time, want.temperature, want.saturated,
                        got.high_time, got.low_time, got.temperature, got.saturated);
               errors++;
            end
         end
         @(negedge clock);
      end
   end

endmodule
